>>> rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Operation codes, status codes and field widths shared by the deque block,
// its channel interfaces and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_BACK  = 3'd0,
    FUNC_PUSH_FRONT = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_PEEK_FRONT = 3'd4,
    FUNC_PEEK_BACK  = 3'd5,
    FUNC_SIZE       = 3'd6,
    FUNC_CLEAR      = 3'd7
  } dq_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } dq_status_e;

endpackage

`default_nettype wire

>>> rtl/dq_if.sv
// ----------------------------------------------------------------------------
// dq_if
// Valid/ready channels of the deque: one for requests and one for responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface dq_req_if import dq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  dq_func_e                  func;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  dq_status_e                status;
  logic signed [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0]        entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // Read data holds when no read is issued.
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// A bounded double-ended queue of signed values kept in a ring inside one
// synchronous RAM. Each request names one operation (push or pop at either
// end, peek at either end, size, clear) and produces exactly one response
// carrying a status, the popped or peeked value and the entry count after the
// operation. The front index, back index and count live in flip-flops and
// are updated at acceptance, while a pop or peek issues its RAM read in the
// same cycle and the registered read data forms the response in the next
// cycle. The response stage is the output register; a new request is taken
// whenever that register is empty or is being drained, so the sustained rate
// is one request per cycle. Pops and peeks on an empty queue answer with the
// empty status, pushes on a full queue with the full status, and both leave
// the state untouched. Entries are never cleared: only held entries are ever
// read, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue import dq_pkg::*; #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dq_req_if.sink    req_i,
  dq_rsp_if.source  rsp_o
);

  // Index and count widths follow from the ring depth.
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  // Working widths large enough for both the stored and the port format.
  localparam int unsigned WIDE_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int unsigned CNTX_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

  // Ring pointers: front points at the front entry, back one past the back.
  logic [IDX_W-1:0] front_q, front_d;
  logic [IDX_W-1:0] back_q, back_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Response stage.
  logic               rsp_valid_q;
  dq_status_e         rsp_status_q, rsp_status_d;
  logic               rsp_rd_q, rsp_rd_d;
  logic [COUNT_W-1:0] rsp_count_q;

  // RAM port signals.
  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic             req_fire;
  logic             rsp_free;
  logic             is_empty, is_full;
  logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;
  logic [WIDE_W-1:0] push_wide;
  logic [WIDE_W-1:0] read_wide;
  logic [CNTX_W-1:0] count_wide;

  // The response register empties or drains this cycle: a new request fits.
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = rsp_free;
  assign req_fire    = req_i.valid && rsp_free;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CNT_FULL);

  assign front_inc = (front_q == IDX_LAST) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? IDX_LAST : front_q - 1'b1;
  assign back_inc  = (back_q == IDX_LAST) ? '0 : back_q + 1'b1;
  assign back_dec  = (back_q == '0) ? IDX_LAST : back_q - 1'b1;

  // Only the low DATA_WIDTH bits of a pushed value are stored; a store wider
  // than the port is filled with zeros above it.
  assign push_wide = WIDE_W'($unsigned(req_i.push_value));
  assign ram_wdata = push_wide[DATA_WIDTH-1:0];

  // Operation decode: index and count updates plus the single RAM access.
  always_comb begin
    front_d      = front_q;
    back_d       = back_q;
    count_d      = count_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = back_q;
    ram_raddr    = front_q;
    rsp_status_d = STATUS_OK;
    rsp_rd_d     = 1'b0;

    case (req_i.func)
      FUNC_PUSH_BACK: begin
        if (is_full) begin
          rsp_status_d = STATUS_FULL;
        end else begin
          ram_we  = 1'b1;
          back_d  = back_inc;
          count_d = count_q + 1'b1;
        end
      end
      FUNC_PUSH_FRONT: begin
        if (is_full) begin
          rsp_status_d = STATUS_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = front_dec;
          front_d   = front_dec;
          count_d   = count_q + 1'b1;
        end
      end
      FUNC_POP_FRONT: begin
        if (is_empty) begin
          rsp_status_d = STATUS_EMPTY;
        end else begin
          ram_re   = 1'b1;
          rsp_rd_d = 1'b1;
          front_d  = front_inc;
          count_d  = count_q - 1'b1;
        end
      end
      FUNC_POP_BACK: begin
        if (is_empty) begin
          rsp_status_d = STATUS_EMPTY;
        end else begin
          ram_re    = 1'b1;
          rsp_rd_d  = 1'b1;
          ram_raddr = back_dec;
          back_d    = back_dec;
          count_d   = count_q - 1'b1;
        end
      end
      FUNC_PEEK_FRONT: begin
        if (is_empty) begin
          rsp_status_d = STATUS_EMPTY;
        end else begin
          ram_re   = 1'b1;
          rsp_rd_d = 1'b1;
        end
      end
      FUNC_PEEK_BACK: begin
        if (is_empty) begin
          rsp_status_d = STATUS_EMPTY;
        end else begin
          ram_re    = 1'b1;
          rsp_rd_d  = 1'b1;
          ram_raddr = back_dec;
        end
      end
      FUNC_SIZE: begin
        rsp_status_d = STATUS_OK;
      end
      FUNC_CLEAR: begin
        front_d = '0;
        back_d  = '0;
        count_d = '0;
      end
      default: begin
        rsp_status_d = STATUS_OK;
      end
    endcase

    // Nothing happens without an accepted request.
    if (!req_fire) begin
      front_d = front_q;
      back_d  = back_q;
      count_d = count_q;
      ram_we  = 1'b0;
      ram_re  = 1'b0;
    end
  end

  // The count field keeps only its low bits when the ring is deeper.
  assign count_wide = CNTX_W'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
      if (rsp_free) begin
        rsp_valid_q <= req_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_status_q <= rsp_status_d;
      rsp_rd_q     <= rsp_rd_d;
      rsp_count_q  <= count_wide[COUNT_W-1:0];
    end
  end

  // A write and a read never share a cycle, and a read issued right after a
  // write sees the written data, so the ring needs no forwarding.
  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The RAM read register holds while the response stalls, because no new
  // request (and so no new read) is taken until it drains.
  assign read_wide = WIDE_W'($signed(ram_rdata));

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.read_value  = rsp_rd_q ? $signed(read_wide[VALUE_W-1:0]) : '0;
  assign rsp_o.entry_count = rsp_count_q;

endmodule

`default_nettype wire

>>> rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks of the deque's response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_checker import dq_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               req_valid_i,
  input wire logic               req_ready_i,
  input wire logic               rsp_valid_i,
  input wire logic               rsp_ready_i,
  input wire logic [STATUS_W-1:0] rsp_status_i,
  input wire logic [VALUE_W-1:0] rsp_read_value_i,
  input wire logic [COUNT_W-1:0] rsp_entry_count_i
);

  localparam int unsigned        DEPTH_X = (DEPTH > 2047) ? 32 : COUNT_W;
  localparam logic [DEPTH_X-1:0] FULL_X  = DEPTH_X'(DEPTH);

  // Every accepted request yields a response in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> rsp_valid_i)
    else $error("accepted request produced no response");

  // A response never appears without a request accepted just before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_valid_i && req_ready_i))
    else $error("response appeared without a request");

  // A stalled response keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      ($stable(rsp_status_i) && $stable(rsp_read_value_i) && $stable(rsp_entry_count_i)))
    else $error("stalled response changed");

  // An empty refusal reports no value and an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_status_i == STATUS_EMPTY) |->
      (rsp_read_value_i == '0 && rsp_entry_count_i == '0))
    else $error("empty refusal with value or nonzero count");

  // A full refusal reports no value and a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_status_i == STATUS_FULL) |->
      (rsp_read_value_i == '0 && rsp_entry_count_i == FULL_X[COUNT_W-1:0]))
    else $error("full refusal with value or wrong count");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH (DEPTH)
) u_dq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_read_value_i  (rsp_o.read_value),
  .rsp_entry_count_i (rsp_o.entry_count)
);

`default_nettype wire
